### rtl/lwc_pkg.sv
// Package for the Lehmann witness check: payload structs, verdict codes,
// sequencer step addresses and the microcode table.
// No dependencies; used by lehmann_witness_check.
package lwc_pkg;

   // default working width of n and a
   localparam int NUM_WIDTH_DEF = 32;
   localparam int FIELD_W       = 32;

   // verdict codes on the result word
   typedef enum logic [2:0] {
      V_COMPOSITE = 3'd0,
      V_PRIME     = 3'd1,
      V_PASS      = 3'd2,
      V_FAIL      = 3'd3,
      V_BAD_WIT   = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [FIELD_W-1:0] candidate;
      logic [FIELD_W-1:0] witness;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] residue;
      verdict_type        verdict;
   } rsp_type;

   // program addresses of the sequencer
   typedef enum logic [3:0] {
      P_IDLE  = 4'd0,
      P_CHECK = 4'd1,
      P_TEST  = 4'd2,
      P_ODD   = 4'd3,
      P_MULR  = 4'd4,
      P_SHIFT = 4'd5,
      P_MULS  = 4'd6,
      P_BACK  = 4'd7,
      P_FINAL = 4'd8,
      P_EMIT  = 4'd9
   } step_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NOP,
      OP_CHECK,
      OP_PREP,
      OP_MULR,
      OP_SHIFT,
      OP_MULS,
      OP_FINAL,
      OP_EMIT
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_START,
      C_SPECIAL,
      C_E_ZERO,
      C_E_EVEN,
      C_MUL_BUSY,
      C_E_LAST
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   // microcode ROM: one control word per step; jump taken when cond holds,
   // otherwise fall through to the next address
   function automatic ctrl_type ucode(step_type s);
      ctrl_type w;
      begin
         case (s)
            P_IDLE:  w = '{OP_NOP,   C_NO_START, P_IDLE};
            P_CHECK: w = '{OP_CHECK, C_SPECIAL,  P_EMIT};
            P_TEST:  w = '{OP_PREP,  C_E_ZERO,   P_FINAL};
            P_ODD:   w = '{OP_NOP,   C_E_EVEN,   P_SHIFT};
            P_MULR:  w = '{OP_MULR,  C_MUL_BUSY, P_MULR};
            P_SHIFT: w = '{OP_SHIFT, C_E_LAST,   P_FINAL};
            P_MULS:  w = '{OP_MULS,  C_MUL_BUSY, P_MULS};
            P_BACK:  w = '{OP_NOP,   C_ALWAYS,   P_TEST};
            P_FINAL: w = '{OP_FINAL, C_NEVER,    P_EMIT};
            P_EMIT:  w = '{OP_EMIT,  C_ALWAYS,   P_IDLE};
            default: w = '{OP_NOP,   C_ALWAYS,   P_IDLE};
         endcase
         return w;
      end
   endfunction

endpackage

### rtl/lehmann_witness_check.sv
// Lehmann witness check: one round r = a^((n-1)/2) mod n with a verdict.
// Depends on lwc_pkg (payload structs, verdict codes, microcode table).

// Usage: raise start with a candidate and a witness on req_item while busy is
// low; the word is taken at that edge and busy stays high until the result
// has been shown. The result appears on rsp_item for exactly one cycle with
// rsp_valid high and must be captured then; it cannot be stalled. Precheck
// cases (n at most 1, even n, n = 2, witness outside 2..n-1) skip the
// exponentiation and go straight to the result. In a full round each modular
// product runs one multiplier bit per cycle through a single shared
// shift-and-add unit under a microcoded sequencer. The next word is taken in
// the cycle after rsp_valid.
module lehmann_witness_check #(
   parameter int NUM_WIDTH = lwc_pkg::NUM_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lwc_pkg::req_type req_item,
   output logic            rsp_valid,
   output lwc_pkg::rsp_type rsp_item
);

   localparam int CW = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

   lwc_pkg::step_type    step_ff, step_in;
   lwc_pkg::ctrl_type    ctrl;
   logic                 jump;

   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] a_ff, a_in;
   logic [NUM_WIDTH-1:0] res_ff, res_in;
   logic [NUM_WIDTH-1:0] sq_ff, sq_in;
   logic [NUM_WIDTH-1:0] e_ff, e_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] out_res_ff, out_res_in;
   lwc_pkg::verdict_type verdict_ff, verdict_in;

   logic                 accept;
   logic                 special;
   lwc_pkg::verdict_type special_v;
   logic [NUM_WIDTH-1:0] n_less1;
   logic [NUM_WIDTH-1:0] mul_x;
   logic [NUM_WIDTH-1:0] acc_dbl;
   logic [NUM_WIDTH-1:0] acc_step;

   // (x + y) mod m for x, y below m
   function automatic logic [NUM_WIDTH-1:0] add_mod(
      input logic [NUM_WIDTH-1:0] x,
      input logic [NUM_WIDTH-1:0] y,
      input logic [NUM_WIDTH-1:0] m
   );
      logic [NUM_WIDTH:0] s;
      begin
         s = {1'b0, x} + {1'b0, y};
         if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
         end
         return s[NUM_WIDTH-1:0];
      end
   endfunction

   assign accept  = start && !busy;
   assign busy    = (step_ff != lwc_pkg::P_IDLE);
   assign ctrl    = lwc_pkg::ucode(step_ff);
   assign n_less1 = n_ff - NUM_WIDTH'(1);

   // classify the early-exit cases
   always_comb begin
      special   = 1'b1;
      special_v = lwc_pkg::V_COMPOSITE;
      if (n_ff <= NUM_WIDTH'(1) || (n_ff > NUM_WIDTH'(2) && !n_ff[0])) begin
         special_v = lwc_pkg::V_COMPOSITE;
      end else if (n_ff == NUM_WIDTH'(2)) begin
         special_v = lwc_pkg::V_PRIME;
      end else if (a_ff < NUM_WIDTH'(2) || a_ff >= n_ff) begin
         special_v = lwc_pkg::V_BAD_WIT;
      end else begin
         special   = 1'b0;
      end
   end

   // evaluate the jump condition of the current control word
   always_comb begin
      case (ctrl.cond)
         lwc_pkg::C_NEVER:    jump = 1'b0;
         lwc_pkg::C_ALWAYS:   jump = 1'b1;
         lwc_pkg::C_NO_START: jump = !start;
         lwc_pkg::C_SPECIAL:  jump = special;
         lwc_pkg::C_E_ZERO:   jump = (e_ff == '0);
         lwc_pkg::C_E_EVEN:   jump = !e_ff[0];
         lwc_pkg::C_MUL_BUSY: jump = (cnt_ff != '0);
         lwc_pkg::C_E_LAST:   jump = (e_ff[NUM_WIDTH-1:1] == '0);
         default:             jump = 1'b0;
      endcase
   end

   // advance the step counter or jump
   always_comb begin
      if (jump) begin
         step_in = ctrl.target;
      end else begin
         step_in = lwc_pkg::step_type'(step_ff + 4'd1);
      end
   end

   // one multiplier bit per cycle: acc = 2*acc + bit*x, all mod n
   assign mul_x    = (ctrl.op == lwc_pkg::OP_MULR) ? res_ff : sq_ff;
   assign acc_dbl  = add_mod(acc_ff, acc_ff, n_ff);
   assign acc_step = sq_ff[cnt_ff] ? add_mod(acc_dbl, mul_x, n_ff) : acc_dbl;

   // datapath controlled by the op field
   always_comb begin
      n_in       = n_ff;
      a_in       = a_ff;
      res_in     = res_ff;
      sq_in      = sq_ff;
      e_in       = e_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      out_res_in = out_res_ff;
      verdict_in = verdict_ff;
      rsp_valid  = 1'b0;
      case (ctrl.op)
         lwc_pkg::OP_NOP: begin
            if (accept) begin
               n_in = NUM_WIDTH'(req_item.candidate);
               a_in = NUM_WIDTH'(req_item.witness);
            end
         end
         lwc_pkg::OP_CHECK: begin
            out_res_in = '0;
            verdict_in = special_v;
            res_in     = NUM_WIDTH'(1);
            sq_in      = a_ff;
            e_in       = n_less1 >> 1;
         end
         lwc_pkg::OP_PREP: begin
            acc_in = '0;
            cnt_in = CW'(NUM_WIDTH - 1);
         end
         lwc_pkg::OP_MULR: begin
            acc_in = acc_step;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               res_in = acc_step;
            end
         end
         lwc_pkg::OP_SHIFT: begin
            e_in   = e_ff >> 1;
            acc_in = '0;
            cnt_in = CW'(NUM_WIDTH - 1);
         end
         lwc_pkg::OP_MULS: begin
            acc_in = acc_step;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               sq_in = acc_step;
            end
         end
         lwc_pkg::OP_FINAL: begin
            out_res_in = res_ff;
            if (res_ff == NUM_WIDTH'(1) || res_ff == n_less1) begin
               verdict_in = lwc_pkg::V_PASS;
            end else begin
               verdict_in = lwc_pkg::V_FAIL;
            end
         end
         lwc_pkg::OP_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // drive the result word from the output registers
   assign rsp_item.residue = lwc_pkg::FIELD_W'(out_res_ff);
   assign rsp_item.verdict = verdict_ff;

   // hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lwc_pkg::P_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // datapath registers need no reset
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      a_ff       <= a_in;
      res_ff     <= res_in;
      sq_ff      <= sq_in;
      e_ff       <= e_in;
      acc_ff     <= acc_in;
      cnt_ff     <= cnt_in;
      out_res_ff <= out_res_in;
      verdict_ff <= verdict_in;
   end

`ifndef ASSERT_OFF
   // a result word is shown for a single cycle only
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // an accepted word always starts with the precheck step
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step_ff == lwc_pkg::P_CHECK))
      else $error("accepted word did not enter the precheck");

   // a passing round reports a residue of 1 or n-1
   a_pass_residue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && verdict_ff == lwc_pkg::V_PASS) |->
         (out_res_ff == NUM_WIDTH'(1) || out_res_ff == n_less1))
      else $error("pass verdict with wrong residue");

   // early-exit verdicts carry a zero residue
   a_zero_residue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (verdict_ff == lwc_pkg::V_COMPOSITE ||
                     verdict_ff == lwc_pkg::V_PRIME ||
                     verdict_ff == lwc_pkg::V_BAD_WIT)) |-> (out_res_ff == '0))
      else $error("precheck verdict with nonzero residue");
`endif

endmodule
